// ===== rtl/spt_pkg.sv =====
// Shared types and constants for the sextupole particle tracking unit.
// Used by the controller, the datapath, the arithmetic unit and the top level.
`default_nettype none
package spt_pkg;

	typedef enum logic {AM_MULQ, AM_MULDIV} arith_mode_t;

	typedef enum logic [4:0] {
		SRC_X, SRC_PX, SRC_Y, SRC_PY, SRC_PATH,
		SRC_H, SRC_L1, SRC_L2, SRC_HK, SRC_K1, SRC_K2, SRC_T, SRC_U,
		SRC_LEN, SRC_ONE, SRC_C1, SRC_C2, SRC_D1, SRC_D2, SRC_KS
	} src_t;

	typedef enum logic [2:0] {DIV_DEN, DIV_DEN2, DIV_ONE, DIV_COEF, DIV_NSL} div_sel_t;

	typedef enum logic [2:0] {CB_WRITE, CB_ADD, CB_SUB, CB_ADDC, CB_SUBC} comb_t;

	typedef struct packed {
		arith_mode_t mode;
		src_t        a;
		src_t        b;
		div_sel_t    c;
		src_t        dst;
		comb_t       comb;
	} uop_t;

	typedef struct packed {
		logic load;
		logic issue;
		uop_t uop;
	} cmd_t;

	typedef struct packed {
		logic op_done;
		logic invalid;
		logic zero_len;
	} status_t;

	typedef enum logic [2:0] {ST_IDLE, ST_CHECK, ST_RUN, ST_WAIT, ST_RESULT} ctrl_state_t;

	typedef enum logic [1:0] {PH_SETUP, PH_SLICE, PH_THIN} phase_t;

	typedef enum logic [2:0] {AR_IDLE, AR_MUL, AR_CHK, AR_DIV, AR_FIN} ar_state_t;

	localparam logic [1:0] REG_LEN    = 2'd0;
	localparam logic [1:0] REG_K2     = 2'd1;
	localparam logic [1:0] REG_SLICES = 2'd2;

	localparam logic [2:0] LAST_SETUP_OP = 3'd5;
	localparam logic [2:0] LAST_STEP_OP  = 3'd4;
	localparam logic [2:0] LAST_SUB      = 3'd6;
	localparam logic [2:0] MID_SUB       = 3'd3;

	localparam logic [63:0] COEF_DEN = 64'd1000000000000000000;
	localparam logic signed [63:0] C1_NUM = 64'sd675603595979828817;
	localparam logic signed [63:0] C2_NUM = -64'sd175603595979828817;
	localparam logic signed [63:0] D1_NUM = 64'sd1351207191959657634;
	localparam logic signed [63:0] D2_NUM = -64'sd1702414383919315268;

	localparam logic [63:0] CAP62 = 64'h3FFF_FFFF_FFFF_FFFF;
	localparam logic [47:0] MAX48 = 48'h7FFF_FFFF_FFFF;
	localparam logic [47:0] MIN48 = 48'h8000_0000_0000;

endpackage
`default_nettype wire

// ===== rtl/sextupole_particle_tracking_unit.sv =====
// Top level of the sextupole particle tracking unit: APB register block,
// slice count clamp, spt_ctrl and spt_datapath. Uses spt_pkg.
//
//   channel   handshake                       payload
//   config    psel/penable/pwrite/pready      paddr, pwdata, prdata (64 bit)
//   item in   start, accepted when !busy      x_in .. delta_in
//   result    done, one-cycle strobe          x_out .. delta_out, flags
//
// One item at a time. Each operation runs on the shared multiply-divide unit;
// a product skips the divide, as does a multiply-divide whose quotient overflows
// or whose divisor is zero. An item runs a check, then setup and its slices, or
// a thin kick; an invalid one just the check. done follows in the next cycle.
// Reset clears all control state; no clearing pass.
// The result cannot be stalled; a new item may start in the done cycle.
`default_nettype none
module sextupole_particle_tracking_unit #(
	parameter int MAX_SLICES = 64,
	parameter int FRAC_BITS  = 40
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     psel,
	input  wire                     penable,
	input  wire                     pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [63:0]        pwdata,
	output logic [63:0]             prdata,
	output logic                    pready,
	input  wire                     start,
	output logic                    busy,
	input  wire logic signed [47:0] x_in,
	input  wire logic signed [47:0] px_in,
	input  wire logic signed [47:0] y_in,
	input  wire logic signed [47:0] py_in,
	input  wire logic signed [47:0] path_in,
	input  wire logic signed [47:0] delta_in,
	output logic                    done,
	output logic signed [47:0]      x_out,
	output logic signed [47:0]      px_out,
	output logic signed [47:0]      y_out,
	output logic signed [47:0]      py_out,
	output logic signed [47:0]      path_out,
	output logic signed [47:0]      delta_out,
	output logic                    invalid_momentum,
	output logic                    saturated
);

	localparam int NW = $clog2(MAX_SLICES + 1);

	logic [46:0]        len_q;
	logic signed [47:0] k2_q;
	logic [6:0]         slices_q;
	logic [NW-1:0]      n_slices;
	logic               wr;
	spt_pkg::cmd_t      cmd;
	spt_pkg::status_t   status;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= 47'd0;
			k2_q     <= 48'sd0;
			slices_q <= 7'd1;
		end else if (wr) begin
			unique case (paddr[4:3])
				spt_pkg::REG_LEN:    len_q    <= pwdata[46:0];
				spt_pkg::REG_K2:     k2_q     <= pwdata[47:0];
				spt_pkg::REG_SLICES: slices_q <= pwdata[6:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:3])
			spt_pkg::REG_LEN:    prdata = {17'd0, len_q};
			spt_pkg::REG_K2:     prdata = {{16{k2_q[47]}}, k2_q};
			spt_pkg::REG_SLICES: prdata = {57'd0, slices_q};
			default:             prdata = 64'd0;
		endcase
		if (slices_q == 7'd0)
			n_slices = NW'(1);
		else if (32'(slices_q) > MAX_SLICES)
			n_slices = NW'(MAX_SLICES);
		else
			n_slices = NW'(slices_q);
	end

	spt_ctrl #(.NW(NW)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.done     (done),
		.n_slices (n_slices),
		.cmd      (cmd),
		.status   (status)
	);

	spt_datapath #(.FRAC_BITS(FRAC_BITS), .NW(NW)) u_datapath (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.status             (status),
		.element_length     (len_q),
		.sextupole_strength (k2_q),
		.n_slices           (n_slices),
		.x_in               (x_in),
		.px_in              (px_in),
		.y_in               (y_in),
		.py_in              (py_in),
		.path_in            (path_in),
		.delta_in           (delta_in),
		.x_out              (x_out),
		.px_out             (px_out),
		.y_out              (y_out),
		.py_out             (py_out),
		.path_out           (path_out),
		.delta_out          (delta_out),
		.invalid_momentum   (invalid_momentum),
		.saturated          (saturated)
	);

endmodule
`default_nettype wire

// ===== rtl/spt_arith.sv =====
// Shared multiply and multiply-divide unit: 64x64 product from four 32x32
// partial products, then a restoring divide one quotient bit a cycle. Uses spt_pkg.
`default_nettype none
module spt_arith #(
	parameter int FRAC_BITS = 40
) (
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	input  wire spt_pkg::arith_mode_t mode,
	input  wire logic signed [63:0]  a,
	input  wire logic signed [63:0]  b,
	input  wire logic [63:0]         c,
	output logic                     done,
	output logic signed [63:0]       res,
	output logic                     sat
);

	spt_pkg::ar_state_t state_q, state_d;
	logic [5:0]          cnt_q;
	spt_pkg::arith_mode_t mode_q;
	logic                neg_q;
	logic [63:0]         ma_q, mb_q, c_q;
	logic [127:0]        acc_q;
	logic [63:0]         rem_q, lo_q, m_q;
	logic                ov_q;

	logic [31:0]  ah, bh;
	logic [63:0]  pp;
	logic [127:0] pp_sh;
	logic [64:0]  dv_t, dv_diff;
	logic         dv_ge;
	logic [63:0]  rem_n;
	logic         capped;
	logic [63:0]  mm;

	always_comb begin
		ah = cnt_q[0] ? ma_q[63:32] : ma_q[31:0];
		bh = cnt_q[1] ? mb_q[63:32] : mb_q[31:0];
		pp = ah * bh;
		case (cnt_q[1:0])
			2'd0:    pp_sh = {64'd0, pp};
			2'd3:    pp_sh = {pp, 64'd0};
			default: pp_sh = {32'd0, pp, 32'd0};
		endcase
		dv_t    = {rem_q, lo_q[63]};
		dv_diff = dv_t - {1'b0, c_q};
		dv_ge   = dv_t >= {1'b0, c_q};
		rem_n   = dv_ge ? dv_diff[63:0] : dv_t[63:0];
		capped  = ov_q || (m_q > spt_pkg::CAP62);
		mm      = capped ? spt_pkg::CAP62 : m_q;
		res     = neg_q ? $signed(64'd0 - mm) : $signed(mm);
		done    = state_q == spt_pkg::AR_FIN;
		sat     = done && capped;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			spt_pkg::AR_IDLE: if (start) state_d = spt_pkg::AR_MUL;
			spt_pkg::AR_MUL:  if (cnt_q[1:0] == 2'd3) state_d = spt_pkg::AR_CHK;
			spt_pkg::AR_CHK: begin
				if (mode_q == spt_pkg::AM_MULQ || c_q == 64'd0 || acc_q[127:64] >= c_q)
					state_d = spt_pkg::AR_FIN;
				else
					state_d = spt_pkg::AR_DIV;
			end
			spt_pkg::AR_DIV:  if (cnt_q == 6'd63) state_d = spt_pkg::AR_FIN;
			spt_pkg::AR_FIN:  state_d = spt_pkg::AR_IDLE;
			default:          state_d = spt_pkg::AR_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spt_pkg::AR_IDLE;
			cnt_q   <= 6'd0;
		end else begin
			state_q <= state_d;
			if (state_q == spt_pkg::AR_IDLE || state_q == spt_pkg::AR_CHK)
				cnt_q <= 6'd0;
			else
				cnt_q <= cnt_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			spt_pkg::AR_IDLE: begin
				if (start) begin
					mode_q <= mode;
					neg_q  <= a[63] ^ b[63];
					ma_q   <= a[63] ? 64'd0 - a : a;
					mb_q   <= b[63] ? 64'd0 - b : b;
					c_q    <= c;
					acc_q  <= 128'd0;
				end
			end
			spt_pkg::AR_MUL: acc_q <= acc_q + pp_sh;
			spt_pkg::AR_CHK: begin
				rem_q <= acc_q[127:64];
				lo_q  <= acc_q[63:0];
				if (mode_q == spt_pkg::AM_MULQ) begin
					m_q  <= acc_q[FRAC_BITS +: 64];
					ov_q <= |(acc_q >> (62 + FRAC_BITS));
				end else if (c_q == 64'd0) begin
					m_q  <= 64'd0;
					ov_q <= 1'b0;
				end else begin
					m_q  <= 64'd0;
					ov_q <= acc_q[127:64] >= c_q;
				end
			end
			spt_pkg::AR_DIV: begin
				rem_q <= rem_n;
				lo_q  <= {lo_q[62:0], dv_ge};
				if (cnt_q == 6'd63) m_q <= {lo_q[62:0], dv_ge};
			end
			default: ;
		endcase
	end

endmodule
`default_nettype wire

// ===== rtl/spt_datapath.sv =====
// Datapath: coordinate and coefficient registers, operand selection,
// accumulate and clip, around the shared spt_arith unit. Uses spt_pkg.
`default_nettype none
module spt_datapath #(
	parameter int FRAC_BITS = 40,
	parameter int NW        = 7
) (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire spt_pkg::cmd_t      cmd,
	output spt_pkg::status_t        status,
	input  wire logic [46:0]        element_length,
	input  wire logic signed [47:0] sextupole_strength,
	input  wire logic [NW-1:0]      n_slices,
	input  wire logic signed [47:0] x_in,
	input  wire logic signed [47:0] px_in,
	input  wire logic signed [47:0] y_in,
	input  wire logic signed [47:0] py_in,
	input  wire logic signed [47:0] path_in,
	input  wire logic signed [47:0] delta_in,
	output logic signed [47:0]      x_out,
	output logic signed [47:0]      px_out,
	output logic signed [47:0]      y_out,
	output logic signed [47:0]      py_out,
	output logic signed [47:0]      path_out,
	output logic signed [47:0]      delta_out,
	output logic                    invalid_momentum,
	output logic                    saturated
);

	localparam logic [63:0] ONE_FX   = 64'd1 << FRAC_BITS;
	localparam logic [63:0] ZERO_LIM = ((64'd1 << FRAC_BITS) + 64'd99999999) / 64'd100000000;

	logic signed [47:0] x_q, px_q, y_q, py_q, path_q, delta_q;
	logic signed [63:0] den_q, h_q, l1_q, l2_q, hk_q, k1_q, k2_q, t_q, u_q;
	logic               sat_q;
	spt_pkg::uop_t      uop_q;

	logic signed [63:0] op_a, op_b, base, new_val;
	logic [63:0]        op_c;
	logic               ar_done, ar_sat;
	logic signed [63:0] ar_res;
	logic [64:0]        sum;
	logic               over, under, clip_sat, is_sub, is_clip;
	logic [47:0]        clipped;

	function automatic logic signed [63:0] sx48(input logic signed [47:0] v);
		return {{16{v[47]}}, v};
	endfunction

	function automatic logic signed [63:0] rd(input spt_pkg::src_t s);
		logic signed [63:0] v;
		case (s)
			spt_pkg::SRC_X:    v = sx48(x_q);
			spt_pkg::SRC_PX:   v = sx48(px_q);
			spt_pkg::SRC_Y:    v = sx48(y_q);
			spt_pkg::SRC_PY:   v = sx48(py_q);
			spt_pkg::SRC_PATH: v = sx48(path_q);
			spt_pkg::SRC_H:    v = h_q;
			spt_pkg::SRC_L1:   v = l1_q;
			spt_pkg::SRC_L2:   v = l2_q;
			spt_pkg::SRC_HK:   v = hk_q;
			spt_pkg::SRC_K1:   v = k1_q;
			spt_pkg::SRC_K2:   v = k2_q;
			spt_pkg::SRC_T:    v = t_q;
			spt_pkg::SRC_U:    v = u_q;
			spt_pkg::SRC_LEN:  v = $signed({17'd0, element_length});
			spt_pkg::SRC_ONE:  v = 64'sd1;
			spt_pkg::SRC_C1:   v = spt_pkg::C1_NUM;
			spt_pkg::SRC_C2:   v = spt_pkg::C2_NUM;
			spt_pkg::SRC_D1:   v = spt_pkg::D1_NUM;
			spt_pkg::SRC_D2:   v = spt_pkg::D2_NUM;
			spt_pkg::SRC_KS:   v = sx48(sextupole_strength);
			default:           v = 64'sd0;
		endcase
		return v;
	endfunction

	always_comb begin
		op_a = rd(cmd.uop.a);
		op_b = rd(cmd.uop.b);
		case (cmd.uop.c)
			spt_pkg::DIV_DEN:  op_c = den_q;
			spt_pkg::DIV_DEN2: op_c = {den_q[62:0], 1'b0};
			spt_pkg::DIV_ONE:  op_c = ONE_FX;
			spt_pkg::DIV_COEF: op_c = spt_pkg::COEF_DEN;
			spt_pkg::DIV_NSL:  op_c = 64'(n_slices);
			default:           op_c = 64'd0;
		endcase
	end

	spt_arith #(.FRAC_BITS(FRAC_BITS)) u_arith (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.issue),
		.mode   (cmd.uop.mode),
		.a      (op_a),
		.b      (op_b),
		.c      (op_c),
		.done   (ar_done),
		.res    (ar_res),
		.sat    (ar_sat)
	);

	always_comb begin
		base    = rd(uop_q.dst);
		is_sub  = uop_q.comb == spt_pkg::CB_SUB || uop_q.comb == spt_pkg::CB_SUBC;
		is_clip = uop_q.comb == spt_pkg::CB_ADDC || uop_q.comb == spt_pkg::CB_SUBC;
		sum     = is_sub ? {base[63], base} - {ar_res[63], ar_res}
		                 : {base[63], base} + {ar_res[63], ar_res};
		over    = ~sum[64] & (|sum[63:47]);
		under   = sum[64] & ~(&sum[63:47]);
		clipped = over ? spt_pkg::MAX48 : (under ? spt_pkg::MIN48 : sum[47:0]);
		clip_sat = is_clip && (over || under);
		case (uop_q.comb)
			spt_pkg::CB_WRITE: new_val = ar_res;
			spt_pkg::CB_ADD,
			spt_pkg::CB_SUB:   new_val = $signed(sum[63:0]);
			default:           new_val = sx48($signed(clipped));
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sat_q <= 1'b0;
		end else if (cmd.load) begin
			sat_q <= 1'b0;
		end else if (ar_done) begin
			sat_q <= sat_q | ar_sat | clip_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.issue) uop_q <= cmd.uop;
		if (cmd.load) begin
			x_q     <= x_in;
			px_q    <= px_in;
			y_q     <= y_in;
			py_q    <= py_in;
			path_q  <= path_in;
			delta_q <= delta_in;
			den_q   <= sx48(delta_in) + $signed(ONE_FX);
		end else if (ar_done) begin
			case (uop_q.dst)
				spt_pkg::SRC_X:    x_q    <= new_val[47:0];
				spt_pkg::SRC_PX:   px_q   <= new_val[47:0];
				spt_pkg::SRC_Y:    y_q    <= new_val[47:0];
				spt_pkg::SRC_PY:   py_q   <= new_val[47:0];
				spt_pkg::SRC_PATH: path_q <= new_val[47:0];
				spt_pkg::SRC_H:    h_q    <= new_val;
				spt_pkg::SRC_L1:   l1_q   <= new_val;
				spt_pkg::SRC_L2:   l2_q   <= new_val;
				spt_pkg::SRC_HK:   hk_q   <= new_val;
				spt_pkg::SRC_K1:   k1_q   <= new_val;
				spt_pkg::SRC_K2:   k2_q   <= new_val;
				spt_pkg::SRC_T:    t_q    <= new_val;
				spt_pkg::SRC_U:    u_q    <= new_val;
				default: ;
			endcase
		end
	end

	always_comb begin
		status.op_done   = ar_done;
		status.invalid   = den_q[63] || den_q == 64'sd0;
		status.zero_len  = {17'd0, element_length} < ZERO_LIM;
		x_out            = x_q;
		px_out           = px_q;
		y_out            = y_q;
		py_out           = py_q;
		path_out         = path_q;
		delta_out        = delta_q;
		invalid_momentum = status.invalid;
		saturated        = sat_q;
	end

endmodule
`default_nettype wire

// ===== rtl/spt_ctrl.sv =====
// Controller: sequences setup, slice drift-kick steps and the thin kick as
// operations on the datapath, and runs the start/busy/done handshake. Uses spt_pkg.
`default_nettype none
module spt_ctrl #(
	parameter int NW = 7
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	output logic                 done,
	input  wire logic [NW-1:0]   n_slices,
	output spt_pkg::cmd_t        cmd,
	input  wire spt_pkg::status_t status
);

	spt_pkg::ctrl_state_t state_q, state_d;
	spt_pkg::phase_t      phase_q, phase_d;
	logic [2:0]           op_q, op_d, sub_q, sub_d;
	logic [NW-1:0]        slice_q, slice_d;
	logic                 accept;
	spt_pkg::uop_t        uop;

	function automatic spt_pkg::uop_t mk(input spt_pkg::arith_mode_t m, input spt_pkg::src_t a,
		input spt_pkg::src_t b, input spt_pkg::div_sel_t c, input spt_pkg::src_t d,
		input spt_pkg::comb_t k);
		spt_pkg::uop_t u;
		u.mode = m;
		u.a    = a;
		u.b    = b;
		u.c    = c;
		u.dst  = d;
		u.comb = k;
		return u;
	endfunction

	function automatic spt_pkg::uop_t setup_uop(input logic [2:0] i);
		spt_pkg::uop_t u;
		case (i)
			3'd0: u = mk(spt_pkg::AM_MULDIV, spt_pkg::SRC_LEN, spt_pkg::SRC_ONE,
				spt_pkg::DIV_NSL, spt_pkg::SRC_H, spt_pkg::CB_WRITE);
			3'd1: u = mk(spt_pkg::AM_MULDIV, spt_pkg::SRC_H, spt_pkg::SRC_C1,
				spt_pkg::DIV_COEF, spt_pkg::SRC_L1, spt_pkg::CB_WRITE);
			3'd2: u = mk(spt_pkg::AM_MULDIV, spt_pkg::SRC_H, spt_pkg::SRC_C2,
				spt_pkg::DIV_COEF, spt_pkg::SRC_L2, spt_pkg::CB_WRITE);
			3'd3: u = mk(spt_pkg::AM_MULDIV, spt_pkg::SRC_H, spt_pkg::SRC_KS,
				spt_pkg::DIV_ONE, spt_pkg::SRC_HK, spt_pkg::CB_WRITE);
			3'd4: u = mk(spt_pkg::AM_MULDIV, spt_pkg::SRC_HK, spt_pkg::SRC_D1,
				spt_pkg::DIV_COEF, spt_pkg::SRC_K1, spt_pkg::CB_WRITE);
			default: u = mk(spt_pkg::AM_MULDIV, spt_pkg::SRC_HK, spt_pkg::SRC_D2,
				spt_pkg::DIV_COEF, spt_pkg::SRC_K2, spt_pkg::CB_WRITE);
		endcase
		return u;
	endfunction

	function automatic spt_pkg::uop_t drift_uop(input logic [2:0] i, input spt_pkg::src_t l);
		spt_pkg::uop_t u;
		case (i)
			3'd0: u = mk(spt_pkg::AM_MULDIV, l, spt_pkg::SRC_PX,
				spt_pkg::DIV_DEN, spt_pkg::SRC_X, spt_pkg::CB_ADDC);
			3'd1: u = mk(spt_pkg::AM_MULDIV, l, spt_pkg::SRC_PY,
				spt_pkg::DIV_DEN, spt_pkg::SRC_Y, spt_pkg::CB_ADDC);
			3'd2: u = mk(spt_pkg::AM_MULQ, spt_pkg::SRC_PX, spt_pkg::SRC_PX,
				spt_pkg::DIV_DEN, spt_pkg::SRC_T, spt_pkg::CB_WRITE);
			3'd3: u = mk(spt_pkg::AM_MULQ, spt_pkg::SRC_PY, spt_pkg::SRC_PY,
				spt_pkg::DIV_DEN, spt_pkg::SRC_T, spt_pkg::CB_ADD);
			default: u = mk(spt_pkg::AM_MULDIV, l, spt_pkg::SRC_T,
				spt_pkg::DIV_DEN2, spt_pkg::SRC_PATH, spt_pkg::CB_SUBC);
		endcase
		return u;
	endfunction

	function automatic spt_pkg::uop_t kick_uop(input logic [2:0] i, input spt_pkg::src_t k);
		spt_pkg::uop_t u;
		case (i)
			3'd0: u = mk(spt_pkg::AM_MULQ, spt_pkg::SRC_Y, spt_pkg::SRC_Y,
				spt_pkg::DIV_DEN, spt_pkg::SRC_T, spt_pkg::CB_WRITE);
			3'd1: u = mk(spt_pkg::AM_MULQ, spt_pkg::SRC_X, spt_pkg::SRC_X,
				spt_pkg::DIV_DEN, spt_pkg::SRC_T, spt_pkg::CB_SUB);
			3'd2: u = mk(spt_pkg::AM_MULQ, spt_pkg::SRC_X, spt_pkg::SRC_Y,
				spt_pkg::DIV_DEN, spt_pkg::SRC_U, spt_pkg::CB_WRITE);
			3'd3: u = mk(spt_pkg::AM_MULDIV, k, spt_pkg::SRC_T,
				spt_pkg::DIV_DEN2, spt_pkg::SRC_PX, spt_pkg::CB_ADDC);
			default: u = mk(spt_pkg::AM_MULDIV, k, spt_pkg::SRC_U,
				spt_pkg::DIV_DEN, spt_pkg::SRC_PY, spt_pkg::CB_ADDC);
		endcase
		return u;
	endfunction

	always_comb begin
		case (phase_q)
			spt_pkg::PH_SETUP: uop = setup_uop(op_q);
			spt_pkg::PH_SLICE: begin
				if (sub_q[0])
					uop = kick_uop(op_q, (sub_q == spt_pkg::MID_SUB) ? spt_pkg::SRC_K2
						: spt_pkg::SRC_K1);
				else
					uop = drift_uop(op_q, (sub_q == 3'd0 || sub_q == spt_pkg::LAST_SUB)
						? spt_pkg::SRC_L1 : spt_pkg::SRC_L2);
			end
			default: uop = kick_uop(op_q, spt_pkg::SRC_KS);
		endcase
	end

	always_comb begin
		busy      = !(state_q == spt_pkg::ST_IDLE || state_q == spt_pkg::ST_RESULT);
		done      = state_q == spt_pkg::ST_RESULT;
		accept    = start && !busy;
		cmd.load  = accept;
		cmd.issue = state_q == spt_pkg::ST_RUN;
		cmd.uop   = uop;

		state_d = state_q;
		phase_d = phase_q;
		op_d    = op_q;
		sub_d   = sub_q;
		slice_d = slice_q;
		unique case (state_q)
			spt_pkg::ST_IDLE,
			spt_pkg::ST_RESULT: state_d = accept ? spt_pkg::ST_CHECK : spt_pkg::ST_IDLE;
			spt_pkg::ST_CHECK: begin
				op_d    = 3'd0;
				sub_d   = 3'd0;
				slice_d = '0;
				if (status.invalid) begin
					state_d = spt_pkg::ST_RESULT;
				end else begin
					state_d = spt_pkg::ST_RUN;
					phase_d = status.zero_len ? spt_pkg::PH_THIN : spt_pkg::PH_SETUP;
				end
			end
			spt_pkg::ST_RUN: state_d = spt_pkg::ST_WAIT;
			spt_pkg::ST_WAIT: begin
				if (status.op_done) begin
					state_d = spt_pkg::ST_RUN;
					op_d    = op_q + 3'd1;
					case (phase_q)
						spt_pkg::PH_SETUP: begin
							if (op_q == spt_pkg::LAST_SETUP_OP) begin
								phase_d = spt_pkg::PH_SLICE;
								op_d    = 3'd0;
							end
						end
						spt_pkg::PH_SLICE: begin
							if (op_q == spt_pkg::LAST_STEP_OP) begin
								op_d  = 3'd0;
								sub_d = sub_q + 3'd1;
								if (sub_q == spt_pkg::LAST_SUB) begin
									sub_d   = 3'd0;
									slice_d = slice_q + NW'(1);
									if (slice_q == n_slices - NW'(1))
										state_d = spt_pkg::ST_RESULT;
								end
							end
						end
						default: begin
							if (op_q == spt_pkg::LAST_STEP_OP) state_d = spt_pkg::ST_RESULT;
						end
					endcase
				end
			end
			default: state_d = spt_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= spt_pkg::ST_IDLE;
			phase_q <= spt_pkg::PH_SETUP;
			op_q    <= 3'd0;
			sub_q   <= 3'd0;
			slice_q <= '0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			op_q    <= op_d;
			sub_q   <= sub_d;
			slice_q <= slice_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/spt_checker.sv =====
// Port-level checks for the sextupole particle tracking unit, bound to the top.
// Depends only on the top level's ports.
`default_nettype none
module spt_checker (
	input wire clk,
	input wire arst_n,
	input wire start,
	input wire busy,
	input wire done,
	input wire pready,
	input wire invalid_momentum,
	input wire saturated
);

	a_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done held longer than one cycle");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");

	a_invalid_nosat: assert property (@(posedge clk) disable iff (!arst_n)
		done && invalid_momentum |-> !saturated) else $error("saturated on invalid item");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		pready) else $error("pready low");

endmodule

bind sextupole_particle_tracking_unit spt_checker u_spt_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.pready           (pready),
	.invalid_momentum (invalid_momentum),
	.saturated        (saturated)
);
`default_nettype wire
